// ----- rtl/swa_pkg.sv -----
// ----------------------------------------------------------------------------
// swa_pkg
// widths, exp lookup tables and side-band type for the swish activation core
// ----------------------------------------------------------------------------
package swa_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int BETA_W       = 16;
    localparam int PROD_W       = SAMPLE_W + BETA_W;
    localparam int UCNT_W       = PROD_W - 1;
    localparam int UFRAC_W      = 20;
    localparam int CHUNK_W      = 8;
    localparam int TAB_DEPTH    = 1 << CHUNK_W;
    localparam int EXP_W        = 64;
    localparam int HALF_W       = EXP_W / 2;
    localparam int AE_W         = SAMPLE_W + EXP_W;
    localparam int NUM_W        = AE_W + 1;
    localparam int DEN_W        = EXP_W + 2;
    localparam int QUO_W        = SAMPLE_W;
    localparam int FRONT_STAGES = 8;
    localparam int PIPE_STAGES  = FRONT_STAGES + QUO_W + 1;

    localparam logic [BETA_W-1:0] BETA_RESET = BETA_W'(1 << 12);
    localparam logic [UCNT_W-1:0] UCNT_LIMIT = UCNT_W'(12 << UFRAC_W);
    localparam logic [QUO_W-1:0]  QUO_MAX    = QUO_W'(1 << (SAMPLE_W - 2));

    // elaboration-time fixed point used to build the tables
    localparam int ACC_W          = 256;
    localparam int ACC_FRAC       = 120;
    localparam int SEED_EXP       = 40;
    localparam int SEED_SQUARINGS = SEED_EXP - UFRAC_W;
    localparam int UBITS          = 3 * CHUNK_W;

    typedef logic [ACC_W-1:0] acc_t;
    typedef logic [TAB_DEPTH-1:0][EXP_W-1:0] exp_tab_t;

    typedef struct packed {
        logic                last;
        logic                neg;
        logic                tpos;
        logic                zero;
        logic                big;
        logic [SAMPLE_W-1:0] mag;
    } swa_side_t;

    function automatic acc_t acc_mul(input acc_t p, input acc_t q);
        acc_t prod;
        prod = p * q;
        return prod >> ACC_FRAC;
    endfunction

    // table of exp(-chunk value) in Q64, one 8-bit slice of u = ucnt * 2^-20
    function automatic exp_tab_t exp_tab_build(input int chunk);
        acc_t     bit_exp [UBITS];
        acc_t     one;
        acc_t     z;
        acc_t     v;
        acc_t     rnd;
        exp_tab_t tab;
        one = acc_t'(1) << ACC_FRAC;
        // exp(-2^-40) = 1 - 2^-40 + 2^-81, later terms are below one unit
        z = one - (acc_t'(1) << (ACC_FRAC - SEED_EXP))
            + (acc_t'(1) << (ACC_FRAC - 2 * SEED_EXP - 1));
        for (int s = 0; s < SEED_SQUARINGS; s++) begin
            z = acc_mul(z, z);
        end
        for (int k = 0; k < UBITS; k++) begin
            bit_exp[k] = z;
            z = acc_mul(z, z);
        end
        for (int i = 0; i < TAB_DEPTH; i++) begin
            v = one;
            for (int b = 0; b < CHUNK_W; b++) begin
                if (((i >> b) & 1) != 0) begin
                    v = acc_mul(v, bit_exp[chunk * CHUNK_W + b]);
                end
            end
            rnd = (v + (acc_t'(1) << (ACC_FRAC - EXP_W - 1))) >> (ACC_FRAC - EXP_W);
            if (rnd >= (acc_t'(1) << EXP_W)) begin
                tab[i] = '1;
            end
            else begin
                tab[i] = rnd[EXP_W-1:0];
            end
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB_LO  = exp_tab_build(0);
    localparam exp_tab_t EXP_TAB_MID = exp_tab_build(1);
    localparam exp_tab_t EXP_TAB_HI  = exp_tab_build(2);

endpackage

// ----- rtl/swish_activation_core.sv -----
// ----------------------------------------------------------------------------
// swish_activation_core
// streaming swish y = x * sigmoid(beta * x), Q7.8 samples, Q3.12 beta
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with sample_in and last_in; a word is
//   taken at a rising edge with in_valid high and in_stall low
//   output channel: out_valid / out_stall with sample_out and last_out
//   beta: write beta_gain with cfg_valid; cfg_ready is always high, write only
//   while no words are in flight
// throughput: one word per cycle while in_stall is low, set by the 25-stage pipeline (exp tables,
//   split 32x32 multipliers, 16 one-bit divider stages for the rounding)
// stall: a stalled result holds on the output register; earlier stages keep
//   moving into empty slots, and in_stall rises only when every stage is full
// reset: clears all valid bits and loads beta = 1.0
// ----------------------------------------------------------------------------
module swish_activation_core
    import swa_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic signed [BETA_W-1:0]   beta_gain,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       last_in,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       last_out
);

    logic signed [BETA_W-1:0]   beta_reg;
    logic [PIPE_STAGES-1:0]     vld_reg;
    logic [PIPE_STAGES-1:0]     move;

    logic signed [SAMPLE_W-1:0] s0_x_reg;
    logic                       s0_last_reg;
    logic signed [PROD_W-1:0]   s0_prod_reg;
    logic signed [PROD_W-1:0]   s0_prod_next;

    swa_side_t                  side_reg [PIPE_STAGES-2:1];
    swa_side_t                  s1_side_next;
    logic [PROD_W-1:0]          s1_prod_abs;
    logic [UCNT_W-1:0]          s1_ucnt;
    logic [EXP_W-1:0]           s1_thi_reg;
    logic [EXP_W-1:0]           s1_tmid_reg;
    logic [EXP_W-1:0]           s1_tlo_reg;

    logic [EXP_W-1:0]           s2_pp_hh_reg;
    logic [EXP_W-1:0]           s2_pp_hl_reg;
    logic [EXP_W-1:0]           s2_pp_lh_reg;
    logic [EXP_W-1:0]           s2_pp_ll_reg;
    logic [EXP_W-1:0]           s2_tlo_reg;

    logic [2*EXP_W-1:0]         s3_sum_next;
    logic [EXP_W-1:0]           s3_e12_reg;
    logic [EXP_W-1:0]           s3_tlo_reg;

    logic [EXP_W-1:0]           s4_pp_hh_reg;
    logic [EXP_W-1:0]           s4_pp_hl_reg;
    logic [EXP_W-1:0]           s4_pp_lh_reg;
    logic [EXP_W-1:0]           s4_pp_ll_reg;

    logic [2*EXP_W-1:0]         s5_sum_next;
    logic [EXP_W-1:0]           s5_e_reg;

    logic [HALF_W+SAMPLE_W-1:0] s6_ph_reg;
    logic [HALF_W+SAMPLE_W-1:0] s6_pl_reg;
    logic [EXP_W-1:0]           s6_e_reg;

    logic [AE_W-1:0]            s7_ae_next;
    logic [NUM_W-1:0]           rem_reg [QUO_W:0];
    logic [DEN_W-1:0]           den_reg [QUO_W:0];
    logic [QUO_W-1:0]           quo_reg [QUO_W:0];

    swa_side_t                  fin_side;
    logic [QUO_W-1:0]           fin_n;
    logic [SAMPLE_W:0]          fin_half;
    logic [SAMPLE_W-1:0]        fin_lo;
    logic [SAMPLE_W-1:0]        sample_out_next;
    logic [SAMPLE_W-1:0]        sample_out_reg;
    logic                       last_out_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_reg <= BETA_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            beta_reg <= beta_gain;
        end
    end

    // a stage loads when it or any stage after it is empty, or the output is not stalled
    for (genvar i = 0; i < PIPE_STAGES; i++) begin : g_move
        assign move[i] = ~(&vld_reg[PIPE_STAGES-1:i]) | ~out_stall;
    end

    assign in_stall  = ~move[0];
    assign out_valid = vld_reg[PIPE_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (move[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < PIPE_STAGES; i++)
            begin
                if (move[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // stage 0: beta * x
    assign s0_prod_next = PROD_W'(sample_in) * PROD_W'(beta_reg);

    always_ff @(posedge clk)
    begin
        if (move[0])
        begin
            s0_x_reg    <= sample_in;
            s0_last_reg <= last_in;
            s0_prod_reg <= s0_prod_next;
        end
    end

    // stage 1: magnitudes, special cases, exp table lookups
    always_comb
    begin
        s1_prod_abs       = s0_prod_reg[PROD_W-1] ? (~s0_prod_reg + 1'b1) : s0_prod_reg;
        s1_ucnt           = s1_prod_abs[UCNT_W-1:0];
        s1_side_next.last = s0_last_reg;
        s1_side_next.neg  = s0_x_reg[SAMPLE_W-1];
        s1_side_next.zero = (s0_prod_reg == '0);
        s1_side_next.tpos = ~s0_prod_reg[PROD_W-1] & (s0_prod_reg != '0);
        s1_side_next.big  = (s1_ucnt >= UCNT_LIMIT);
        s1_side_next.mag  = s0_x_reg[SAMPLE_W-1] ? (~s0_x_reg + 1'b1) : s0_x_reg;
    end

    always_ff @(posedge clk)
    begin
        if (move[1])
        begin
            side_reg[1] <= s1_side_next;
            s1_tlo_reg  <= EXP_TAB_LO[s1_ucnt[CHUNK_W-1:0]];
            s1_tmid_reg <= EXP_TAB_MID[s1_ucnt[2*CHUNK_W-1:CHUNK_W]];
            s1_thi_reg  <= EXP_TAB_HI[s1_ucnt[3*CHUNK_W-1:2*CHUNK_W]];
        end
    end

    // side band follows its word through the rest of the pipe
    for (genvar i = 2; i <= PIPE_STAGES - 2; i++) begin : g_side
        always_ff @(posedge clk)
        begin
            if (move[i])
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // stage 2: partial products of hi * mid
    always_ff @(posedge clk)
    begin
        if (move[2])
        begin
            s2_pp_hh_reg <= EXP_W'(s1_thi_reg[EXP_W-1:HALF_W])
                          * EXP_W'(s1_tmid_reg[EXP_W-1:HALF_W]);
            s2_pp_hl_reg <= EXP_W'(s1_thi_reg[EXP_W-1:HALF_W])
                          * EXP_W'(s1_tmid_reg[HALF_W-1:0]);
            s2_pp_lh_reg <= EXP_W'(s1_thi_reg[HALF_W-1:0])
                          * EXP_W'(s1_tmid_reg[EXP_W-1:HALF_W]);
            s2_pp_ll_reg <= EXP_W'(s1_thi_reg[HALF_W-1:0])
                          * EXP_W'(s1_tmid_reg[HALF_W-1:0]);
            s2_tlo_reg   <= s1_tlo_reg;
        end
    end

    // stage 3: sum, keep the upper Q64 half
    assign s3_sum_next = {s2_pp_hh_reg, s2_pp_ll_reg}
                       + ((2*EXP_W)'(s2_pp_hl_reg) << HALF_W)
                       + ((2*EXP_W)'(s2_pp_lh_reg) << HALF_W);

    always_ff @(posedge clk)
    begin
        if (move[3])
        begin
            s3_e12_reg <= s3_sum_next[2*EXP_W-1:EXP_W];
            s3_tlo_reg <= s2_tlo_reg;
        end
    end

    // stage 4: partial products of (hi * mid) * lo
    always_ff @(posedge clk)
    begin
        if (move[4])
        begin
            s4_pp_hh_reg <= EXP_W'(s3_e12_reg[EXP_W-1:HALF_W])
                          * EXP_W'(s3_tlo_reg[EXP_W-1:HALF_W]);
            s4_pp_hl_reg <= EXP_W'(s3_e12_reg[EXP_W-1:HALF_W])
                          * EXP_W'(s3_tlo_reg[HALF_W-1:0]);
            s4_pp_lh_reg <= EXP_W'(s3_e12_reg[HALF_W-1:0])
                          * EXP_W'(s3_tlo_reg[EXP_W-1:HALF_W]);
            s4_pp_ll_reg <= EXP_W'(s3_e12_reg[HALF_W-1:0])
                          * EXP_W'(s3_tlo_reg[HALF_W-1:0]);
        end
    end

    // stage 5: e = exp(-|beta*x|) in Q64
    assign s5_sum_next = {s4_pp_hh_reg, s4_pp_ll_reg}
                       + ((2*EXP_W)'(s4_pp_hl_reg) << HALF_W)
                       + ((2*EXP_W)'(s4_pp_lh_reg) << HALF_W);

    always_ff @(posedge clk)
    begin
        if (move[5])
        begin
            s5_e_reg <= s5_sum_next[2*EXP_W-1:EXP_W];
        end
    end

    // stage 6: |x| * e as two partial products
    always_ff @(posedge clk)
    begin
        if (move[6])
        begin
            s6_ph_reg <= (HALF_W+SAMPLE_W)'(side_reg[5].mag)
                       * (HALF_W+SAMPLE_W)'(s5_e_reg[EXP_W-1:HALF_W]);
            s6_pl_reg <= (HALF_W+SAMPLE_W)'(side_reg[5].mag)
                       * (HALF_W+SAMPLE_W)'(s5_e_reg[HALF_W-1:0]);
            s6_e_reg  <= s5_e_reg;
        end
    end

    // stage 7: round(a*e/(1+e)) = floor((2*a*e + 1 + e) / (2 + 2*e))
    assign s7_ae_next = (AE_W'(s6_ph_reg) << HALF_W) + AE_W'(s6_pl_reg);

    always_ff @(posedge clk)
    begin
        if (move[7])
        begin
            rem_reg[0] <= (NUM_W'(s7_ae_next) << 1) + (NUM_W'(1) << EXP_W) + NUM_W'(s6_e_reg);
            den_reg[0] <= (DEN_W'(1) << (EXP_W + 1)) + (DEN_W'(s6_e_reg) << 1);
            quo_reg[0] <= '0;
        end
    end

    // restoring divider, one quotient bit per stage, msb first
    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        localparam int SH = QUO_W - 1 - k;
        logic [NUM_W:0] diff;

        assign diff = {1'b0, rem_reg[k]} - ((NUM_W+1)'(den_reg[k]) << SH);

        always_ff @(posedge clk)
        begin
            if (move[FRONT_STAGES+k])
            begin
                den_reg[k+1] <= den_reg[k];
                if (!diff[NUM_W])
                begin
                    rem_reg[k+1] <= diff[NUM_W-1:0];
                    quo_reg[k+1] <= quo_reg[k] | (QUO_W'(1) << SH);
                end
                else
                begin
                    rem_reg[k+1] <= rem_reg[k];
                    quo_reg[k+1] <= quo_reg[k];
                end
            end
        end
    end

    // output stage: special cases and sign
    always_comb
    begin
        fin_side = side_reg[PIPE_STAGES-2];
        fin_n    = fin_side.big ? '0 : quo_reg[QUO_W];
        fin_half = ({1'b0, fin_side.mag} + 1'b1) >> 1;
        if (fin_side.zero)
        begin
            // beta*x is zero: x/2 with ties away from zero
            fin_lo = fin_half[SAMPLE_W-1:0];
        end
        else if (fin_side.tpos)
        begin
            fin_lo = fin_side.mag - fin_n;
        end
        else
        begin
            fin_lo = fin_n;
        end
        sample_out_next = fin_side.neg ? (~fin_lo + 1'b1) : fin_lo;
    end

    always_ff @(posedge clk)
    begin
        if (move[PIPE_STAGES-1])
        begin
            sample_out_reg <= sample_out_next;
            last_out_reg   <= fin_side.last;
        end
    end

    assign sample_out = sample_out_reg;
    assign last_out   = last_out_reg;

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&vld_reg && out_stall))
        else $error("input stalled while the pipeline has an empty slot");

    a_quotient_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[PIPE_STAGES-2] |-> (quo_reg[QUO_W] <= QUO_MAX))
        else $error("divider quotient above half of full scale");

    a_result_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[PIPE_STAGES-2] |-> (fin_lo <= fin_side.mag))
        else $error("result magnitude exceeds input magnitude");
`endif

endmodule
